// ===== sv/vector_distance_l2_cosine_assert.svh =====
// Assertion macros shared by the checker of the distance block.
// Each macro expands to one labeled concurrent assertion with an asynchronous reset guard.
`ifndef VECTOR_DISTANCE_L2_COSINE_ASSERT_SVH
`define VECTOR_DISTANCE_L2_COSINE_ASSERT_SVH

// The consequent must hold in the same cycle in which the antecedent ends.
`define VDLC_ASSERT_IMP(name, clk_sig, rst_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent ends.
`define VDLC_ASSERT_NXT(name, clk_sig, rst_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vdlc_pkg.sv =====
// Shared widths, constants, types and the sequencer state type of the distance block.
// No dependencies; every other file of the block but the assertion header imports this package.
package vdlc_pkg;

    localparam int ELEM_W    = 16;
    localparam int ACC_W     = 48;
    localparam int MUL_W     = ACC_W / 2;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int WIDE_W    = 2 * ACC_W + 1;
    localparam int DIST_W    = 32;
    localparam int CNT_W     = 32;
    localparam int QUOT_W    = 32;
    localparam int SQ_OP_W   = ACC_W + 8;
    localparam int SQ_ROOT_W = SQ_OP_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 1;
    localparam int COS_Q_W   = QUOT_W / 2;
    localparam int STEP_W    = 5;

    localparam logic [STEP_W-1:0] ELEM_LAST_STEP = STEP_W'(4);
    localparam logic [STEP_W-1:0] COS_LAST_STEP  = STEP_W'(8);
    localparam logic [STEP_W-1:0] DIV_LAST_STEP  = STEP_W'(QUOT_W - 1);
    localparam logic [STEP_W-1:0] SQ_LAST_STEP   = STEP_W'(SQ_ROOT_W - 1);

    localparam logic [DIST_W-1:0] ONE_Q16  = DIST_W'(32'h0001_0000);
    localparam logic [ACC_W-1:0]  ACC_UMAX = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0]  ACC_SMAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]  ACC_SMIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [DIST_W-1:0]        dist_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_PREP,
        ST_COS_MUL,
        ST_CMP,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } vdlc_state_t;

endpackage

// ===== sv/vdlc_pair_if.sv =====
// Valid/ready channel that carries one element pair of the two input vectors per beat.
// Depends on vdlc_pkg for the element type.
interface vdlc_pair_if import vdlc_pkg::*; ();

    logic  valid;
    logic  ready;
    elem_t elem_a;
    elem_t elem_b;
    logic  last;

    modport source (output valid, elem_a, elem_b, last, input ready);
    modport sink (input valid, elem_a, elem_b, last, output ready);

endinterface

// ===== sv/vdlc_result_if.sv =====
// Valid/ready channel that carries one distance result per beat.
// Depends on vdlc_pkg for the distance and count types.
interface vdlc_result_if import vdlc_pkg::*; ();

    logic  valid;
    logic  ready;
    dist_t distance;
    cnt_t  compare_count;

    modport source (output valid, distance, compare_count, input ready);
    modport sink (input valid, distance, compare_count, output ready);

endinterface

// ===== sv/vector_distance_l2_cosine.sv =====
// Streaming Euclidean / cosine distance; depends on vdlc_pkg, vdlc_pair_if, vdlc_result_if.
// A new element pair is taken only after the single 24x24 multiplier has done the four
// products of the previous pair. After the last beat a result follows a 28-step square root
// (Euclidean) or 9 multiply, 32 divide and 28 root steps (cosine); a zero norm skips all of
// these, a clamped cosine skips divide and root. Reset (rst_n low, asynchronous) clears
// the accumulators, the distance count, the mode register (Euclidean) and the output valid.
module vector_distance_l2_cosine import vdlc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         cfg_we,
    input logic         cfg_wdata,
    vdlc_pair_if.sink   pair,
    vdlc_result_if.source result
);

    // Sequencer and control state.
    vdlc_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              mode_reg;
    logic              out_valid_reg, out_valid_next;
    cnt_t              count_reg, count_next;

    // Accumulators. The dot product is kept as a two's complement bit pattern.
    logic [ACC_W-1:0]  dot_reg, dot_next;
    logic [ACC_W-1:0]  na_reg, na_next;
    logic [ACC_W-1:0]  nb_reg, nb_next;
    logic [ACC_W-1:0]  diff_reg, diff_next;

    // Operand and working registers of the shared arithmetic.
    logic [ELEM_W-1:0]   am_reg, am_next;
    logic [ELEM_W-1:0]   bm_reg, bm_next;
    logic [ELEM_W-1:0]   dm_reg, dm_next;
    logic                neg_reg, neg_next;
    logic                last_reg, last_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ACC_W-1:0]    mag_reg, mag_next;
    logic [WIDE_W-1:0]   wa_reg, wa_next;
    logic [WIDE_W-1:0]   wb_reg, wb_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [SQ_OP_W-1:0]  sq_op_reg, sq_op_next;
    logic [SQ_REM_W-1:0] sq_rem_reg, sq_rem_next;
    logic [SQ_ROOT_W-1:0] sq_root_reg, sq_root_next;
    dist_t               res_reg, res_next;
    dist_t               out_dist_reg, out_dist_next;
    cnt_t                out_count_reg, out_count_next;

    logic ready_int;
    logic pair_fire;
    logic out_load;

    assign pair_fire = pair.valid && ready_int;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // ------------------------------------------------------------------
    // Element conditioning at accept time: magnitudes of a, b and a - b,
    // and the sign of a * b. All magnitudes fit in ELEM_W unsigned bits.
    // ------------------------------------------------------------------
    logic [ELEM_W:0] a_ext, b_ext, d_ext;
    logic [ELEM_W:0] a_neg, b_neg, d_neg;

    assign a_ext = {pair.elem_a[ELEM_W-1], pair.elem_a};
    assign b_ext = {pair.elem_b[ELEM_W-1], pair.elem_b};
    assign d_ext = a_ext - b_ext;
    assign a_neg = ~a_ext + 1'b1;
    assign b_neg = ~b_ext + 1'b1;
    assign d_neg = ~d_ext + 1'b1;

    // ------------------------------------------------------------------
    // The shared multiplier. During a pair it forms |a||b|, |a|^2, |b|^2
    // and |a-b|^2; in cosine mode it forms the 96-bit products na*nb and
    // |dot|^2 as four 24x24 partial products each. Step bit 2 picks the
    // source, bits 1 and 0 pick the halves.
    // ------------------------------------------------------------------
    logic [MUL_W-1:0]  mul_x, mul_y;
    logic [PROD_W-1:0] mul_p;
    logic [ACC_W-1:0]  cos_src_x, cos_src_y;

    assign cos_src_x = step_reg[2] ? mag_reg : na_reg;
    assign cos_src_y = step_reg[2] ? mag_reg : nb_reg;

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        if (state_reg == ST_ELEM)
        begin
            case (step_reg[1:0])
                2'd0:
                begin
                    mul_x = MUL_W'(am_reg);
                    mul_y = MUL_W'(bm_reg);
                end
                2'd1:
                begin
                    mul_x = MUL_W'(am_reg);
                    mul_y = MUL_W'(am_reg);
                end
                2'd2:
                begin
                    mul_x = MUL_W'(bm_reg);
                    mul_y = MUL_W'(bm_reg);
                end
                default:
                begin
                    mul_x = MUL_W'(dm_reg);
                    mul_y = MUL_W'(dm_reg);
                end
            endcase
        end
        else
        begin
            mul_x = step_reg[1] ? cos_src_x[ACC_W-1:MUL_W] : cos_src_x[MUL_W-1:0];
            mul_y = step_reg[0] ? cos_src_y[ACC_W-1:MUL_W] : cos_src_y[MUL_W-1:0];
        end
    end

    assign mul_p = mul_x * mul_y;

    // ------------------------------------------------------------------
    // Accumulate side. The registered product of the previous step is
    // added in, so the product index is the step number minus one.
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] acc_idx;
    logic [ACC_W:0]    dot_term, dot_sum;
    logic [ACC_W-1:0]  dot_sat;
    logic [ACC_W-1:0]  uacc_sel;
    logic [ACC_W:0]    uacc_sum;
    logic [ACC_W-1:0]  uacc_sat;
    logic [WIDE_W-1:0] prod_wide, wide_term, wide_sel, wide_sum;

    assign acc_idx = step_reg - 1'b1;

    // Signed dot product: both terms fit in 49 bits, so the 49-bit sum is
    // exact and a mismatch of its top two bits marks an overflow.
    assign dot_term = neg_reg ? (~{1'b0, prod_reg} + 1'b1) : {1'b0, prod_reg};
    assign dot_sum  = {dot_reg[ACC_W-1], dot_reg} + dot_term;
    assign dot_sat  = (dot_sum[ACC_W] != dot_sum[ACC_W-1])
                    ? (dot_sum[ACC_W] ? ACC_SMIN : ACC_SMAX)
                    : dot_sum[ACC_W-1:0];

    always_comb
    begin
        case (acc_idx[1:0])
            2'd1:    uacc_sel = na_reg;
            2'd2:    uacc_sel = nb_reg;
            default: uacc_sel = diff_reg;
        endcase
    end

    assign uacc_sum = {1'b0, uacc_sel} + {1'b0, prod_reg};
    assign uacc_sat = uacc_sum[ACC_W] ? ACC_UMAX : uacc_sum[ACC_W-1:0];

    // Wide accumulation of the partial products: low-low at weight 0, the
    // cross terms at 2^24 and high-high at 2^48.
    assign prod_wide = WIDE_W'(prod_reg);

    always_comb
    begin
        case (acc_idx[1:0])
            2'd0:    wide_term = prod_wide;
            2'd3:    wide_term = prod_wide << (2 * MUL_W);
            default: wide_term = prod_wide << MUL_W;
        endcase
    end

    assign wide_sel = acc_idx[2] ? wb_reg : wa_reg;
    assign wide_sum = wide_sel + wide_term;

    // ------------------------------------------------------------------
    // Restoring division step. The remainder starts below the divisor,
    // so one shift and one compare-subtract give one quotient bit.
    // ------------------------------------------------------------------
    logic [WIDE_W-1:0] div_sh;
    logic              div_ge;
    logic [WIDE_W-1:0] div_rem;
    logic [QUOT_W-1:0] quot_step;

    assign div_sh    = {wb_reg[WIDE_W-2:0], 1'b0};
    assign div_ge    = div_sh >= wa_reg;
    assign div_rem   = div_ge ? (div_sh - wa_reg) : div_sh;
    assign quot_step = {quot_reg[QUOT_W-2:0], div_ge};

    // ------------------------------------------------------------------
    // Digit-by-digit square root step: two operand bits in, one root bit
    // out. The remainder never exceeds twice the root.
    // ------------------------------------------------------------------
    logic [SQ_REM_W+1:0]  sq_rem4, sq_trial;
    logic                 sq_ge;
    logic [SQ_REM_W-1:0]  sq_rem_step;
    logic [SQ_ROOT_W-1:0] sq_root_step;
    logic [COS_Q_W-1:0]   cos_q;

    assign sq_rem4      = {sq_rem_reg, sq_op_reg[SQ_OP_W-1 -: 2]};
    assign sq_trial     = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge        = sq_rem4 >= sq_trial;
    assign sq_rem_step  = sq_ge ? SQ_REM_W'(sq_rem4 - sq_trial) : SQ_REM_W'(sq_rem4);
    assign sq_root_step = {sq_root_reg[SQ_ROOT_W-2:0], sq_ge};
    assign cos_q        = sq_root_step[COS_Q_W-1:0];

    // ------------------------------------------------------------------
    // Next-state logic of the sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pair_fire)
                begin
                    state_next = ST_ELEM;
                end
            end
            ST_ELEM:
            begin
                if (step_reg == ELEM_LAST_STEP)
                begin
                    state_next = last_reg ? ST_PREP : ST_IDLE;
                end
            end
            ST_PREP:
            begin
                if (!mode_reg)
                begin
                    state_next = ST_SQRT;
                end
                else if ((na_reg == '0) || (nb_reg == '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_COS_MUL;
                end
            end
            ST_COS_MUL:
            begin
                if (step_reg == COS_LAST_STEP)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = (wb_reg >= wa_reg) ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == DIV_LAST_STEP)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (step_reg == SQ_LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values, steered by the sequencer state.
    // ------------------------------------------------------------------
    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        dot_next       = dot_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        diff_next      = diff_reg;
        am_next        = am_reg;
        bm_next        = bm_reg;
        dm_next        = dm_reg;
        neg_next       = neg_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        mag_next       = mag_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        quot_next      = quot_reg;
        sq_op_next     = sq_op_reg;
        sq_rem_next    = sq_rem_reg;
        sq_root_next   = sq_root_reg;
        res_next       = res_reg;
        out_dist_next  = out_dist_reg;
        out_count_next = out_count_reg;

        // The result register drains independently of the sequencer.
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pair_fire)
                begin
                    am_next   = a_ext[ELEM_W] ? a_neg[ELEM_W-1:0] : a_ext[ELEM_W-1:0];
                    bm_next   = b_ext[ELEM_W] ? b_neg[ELEM_W-1:0] : b_ext[ELEM_W-1:0];
                    dm_next   = d_ext[ELEM_W] ? d_neg[ELEM_W-1:0] : d_ext[ELEM_W-1:0];
                    neg_next  = pair.elem_a[ELEM_W-1] ^ pair.elem_b[ELEM_W-1];
                    last_next = pair.last;
                    step_next = '0;
                end
            end
            ST_ELEM:
            begin
                prod_next = mul_p;
                step_next = step_reg + 1'b1;
                if (step_reg != '0)
                begin
                    case (acc_idx[1:0])
                        2'd0:    dot_next  = dot_sat;
                        2'd1:    na_next   = uacc_sat;
                        2'd2:    nb_next   = uacc_sat;
                        default: diff_next = uacc_sat;
                    endcase
                end
            end
            ST_PREP:
            begin
                step_next    = '0;
                sq_op_next   = {diff_reg, 8'h00};
                sq_rem_next  = '0;
                sq_root_next = '0;
                wa_next      = '0;
                wb_next      = '0;
                mag_next     = dot_reg[ACC_W-1] ? (~dot_reg + 1'b1) : dot_reg;
                res_next     = ONE_Q16;
            end
            ST_COS_MUL:
            begin
                prod_next = mul_p;
                step_next = step_reg + 1'b1;
                if (step_reg != '0)
                begin
                    if (acc_idx[2])
                    begin
                        wb_next = wide_sum;
                    end
                    else
                    begin
                        wa_next = wide_sum;
                    end
                end
            end
            ST_CMP:
            begin
                // |dot|^2 >= na*nb means the cosine magnitude clamps to one.
                step_next = '0;
                quot_next = '0;
                res_next  = dot_reg[ACC_W-1] ? {ONE_Q16[DIST_W-2:0], 1'b0} : '0;
            end
            ST_DIV:
            begin
                wb_next   = div_rem;
                quot_next = quot_step;
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST_STEP)
                begin
                    step_next    = '0;
                    sq_op_next   = SQ_OP_W'(quot_step);
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                end
            end
            ST_SQRT:
            begin
                sq_op_next   = {sq_op_reg[SQ_OP_W-3:0], 2'b00};
                sq_rem_next  = sq_rem_step;
                sq_root_next = sq_root_step;
                step_next    = step_reg + 1'b1;
                if (step_reg == SQ_LAST_STEP)
                begin
                    if (mode_reg)
                    begin
                        res_next = dot_reg[ACC_W-1] ? (ONE_Q16 + DIST_W'(cos_q))
                                                    : (ONE_Q16 - DIST_W'(cos_q));
                    end
                    else
                    begin
                        res_next = DIST_W'(sq_root_step);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = res_reg;
                    count_next     = count_reg + 1'b1;
                    out_count_next = count_reg + 1'b1;
                    dot_next       = '0;
                    na_next        = '0;
                    nb_next        = '0;
                    diff_next      = '0;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Port outputs. Pairs are taken only while the sequencer is idle; a
    // finished result waiting in the output register does not block them.
    // ------------------------------------------------------------------
    always_comb
    begin
        ready_int = (state_reg == ST_IDLE);
    end

    assign pair.ready           = ready_int;
    assign result.valid         = out_valid_reg;
    assign result.distance      = out_dist_reg;
    assign result.compare_count = out_count_reg;

    // Control state and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            dot_reg       <= '0;
            na_reg        <= '0;
            nb_reg        <= '0;
            diff_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            dot_reg       <= dot_next;
            na_reg        <= na_next;
            nb_reg        <= nb_next;
            diff_reg      <= diff_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        am_reg        <= am_next;
        bm_reg        <= bm_next;
        dm_reg        <= dm_next;
        neg_reg       <= neg_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        mag_reg       <= mag_next;
        wa_reg        <= wa_next;
        wb_reg        <= wb_next;
        quot_reg      <= quot_next;
        sq_op_reg     <= sq_op_next;
        sq_rem_reg    <= sq_rem_next;
        sq_root_reg   <= sq_root_next;
        res_reg       <= res_next;
        out_dist_reg  <= out_dist_next;
        out_count_reg <= out_count_next;
    end

endmodule

// ===== sv/vdlc_checker.sv =====
// Port-level checker of the distance block and the bind that attaches it to the top level.
// Depends on vdlc_pkg and on the assertion macros of vector_distance_l2_cosine_assert.svh.
`include "vector_distance_l2_cosine_assert.svh"

module vdlc_checker import vdlc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  pair_valid,
    input logic  pair_ready,
    input logic  result_valid,
    input logic  result_ready,
    input dist_t result_distance,
    input cnt_t  result_compare_count
);

    // Every beat starts a multi-cycle pass, so the block is busy right after one.
    `VDLC_ASSERT_NXT(a_busy_after_beat, clk, rst_n, pair_valid && pair_ready, !pair_ready, "pair accepted on consecutive cycles")

    // A result that is not taken stays on the port unchanged.
    `VDLC_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_distance) && $stable(result_compare_count), "stalled result changed")

    // A result that follows a taken one directly carries the next count.
    `VDLC_ASSERT_IMP(a_count_step, clk, rst_n, (result_valid && result_ready) ##1 result_valid, result_compare_count == $past(result_compare_count) + 1'b1, "count did not advance by one")

endmodule

bind vector_distance_l2_cosine vdlc_checker u_vdlc_checker
(
    .clk                  (clk),
    .rst_n                (rst_n),
    .pair_valid           (pair.valid),
    .pair_ready           (pair.ready),
    .result_valid         (result.valid),
    .result_ready         (result.ready),
    .result_distance      (result.distance),
    .result_compare_count (result.compare_count)
);

// ===== bench/tb_vector_distance_l2_cosine.sv =====
// Self-checking bench for vector_distance_l2_cosine: directed and random vector pairs in both metrics.
// Depends on vdlc_pkg, vdlc_pair_if, vdlc_result_if and the block itself.
module tb_vector_distance_l2_cosine;

    import vdlc_pkg::*;

    // The block takes a new beat only once it is through with the last one, and the slowest
    // result is a cosine distance. These bounds leave plenty of margin.
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PAIRS = 310;

    localparam elem_t E_MIN  = 16'sh8000;
    localparam elem_t E_MAX  = 16'sh7FFF;
    localparam elem_t Q4_ONE = 16'sh1000;

    localparam logic MODE_EUCLID = 1'b0;
    localparam logic MODE_COSINE = 1'b1;

    // Bounds of the signed 48-bit dot product accumulator.
    localparam longint DOT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DOT_MIN = -DOT_MAX - 1;

    // Ways of filling the element pairs of one random vector.
    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_EXTREME,
        FILL_SAME,
        FILL_NEG,
        FILL_NEAR,
        FILL_A_ZERO,
        FILL_B_ZERO
    } fill_t;

    typedef struct packed {
        dist_t distance;
        cnt_t  count;
    } dist_record_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    vdlc_pair_if   pair_ch();
    vdlc_result_if res_ch();

    vector_distance_l2_cosine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pair      (pair_ch),
        .result    (res_ch)
    );

    // Shadow state of the block. The mode follows a register write at the same clock edge as the
    // block does; the sums take in every accepted pair beat at once.
    logic               mode_shadow = MODE_EUCLID;
    logic signed [47:0] dot_acc     = '0;
    logic [47:0]        norm_a_acc  = '0;
    logic [47:0]        norm_b_acc  = '0;
    logic [47:0]        diff_sq_acc = '0;
    cnt_t               distances_done = '0;

    // Distances that the block owes us, oldest first.
    dist_record_t owed_distances[$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  src_steady = 1'b0;
    bit  snk_steady = 1'b0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------------------
    // Arithmetic of the distance, written independently of the design.
    // ------------------------------------------------------------------------------------

    // Integer square root, truncated. The operand never exceeds 56 bits, so the root fits
    // in 28 bits and every trial square fits in 64.
    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int k = 31; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    // Cosine distance in Q16.16. The cosine magnitude q is the largest Q1.16 value with
    // q * sqrt(na * nb) <= |dot|, found bit by bit on squared terms so that no root is
    // taken. It is capped at 1.0, and the sign of the dot product picks 1 - q or 1 + q.
    function automatic dist_t cosine_dist(input logic signed [47:0] dot,
                                          input logic [47:0] na, input logic [47:0] nb);
        logic [47:0]  mag;
        logic [95:0]  norm_prod;
        logic [159:0] dot_sq_scaled;
        logic [16:0]  q;
        logic [16:0]  t;
        if (na == 0 || nb == 0)
            return ONE_Q16;
        mag = dot[47] ? -dot : dot;
        norm_prod = na * nb;
        dot_sq_scaled = (160'(mag) * 160'(mag)) << 32;
        q = '0;
        for (int k = 16; k >= 0; k--)
        begin
            t = q | (17'd1 << k);
            if (t <= 17'd65536 && 160'(t) * 160'(t) * 160'(norm_prod) <= dot_sq_scaled)
                q = t;
        end
        return dot[47] ? ONE_Q16 + 32'(q) : ONE_Q16 - 32'(q);
    endfunction

    function automatic logic signed [47:0] add_dot_sat(input logic signed [47:0] acc,
                                                       input longint x);
        longint s;
        s = longint'(acc) + x;
        if (s > DOT_MAX)
            return DOT_MAX[47:0];
        if (s < DOT_MIN)
            return DOT_MIN[47:0];
        return s[47:0];
    endfunction

    function automatic logic [47:0] add_norm_sat(input logic [47:0] acc, input longint x);
        longint unsigned s;
        s = {16'b0, acc} + longint'(x);
        if (s > {16'b0, ACC_UMAX})
            return ACC_UMAX;
        return s[47:0];
    endfunction

    // Folds one accepted pair into the shadow sums. A closing pair produces the expected
    // distance and count and clears the sums for the next vector.
    task automatic fold_pair(input elem_t a, input elem_t b, input logic lst);
        longint          pa;
        longint          pb;
        longint          pd;
        longint unsigned root;
        dist_record_t    rec;
        pa = a;
        pb = b;
        pd = pa - pb;
        dot_acc     = add_dot_sat(dot_acc, pa * pb);
        norm_a_acc  = add_norm_sat(norm_a_acc, pa * pa);
        norm_b_acc  = add_norm_sat(norm_b_acc, pb * pb);
        diff_sq_acc = add_norm_sat(diff_sq_acc, pd * pd);
        if (lst)
        begin
            distances_done++;
            if (mode_shadow == MODE_COSINE)
                rec.distance = cosine_dist(dot_acc, norm_a_acc, norm_b_acc);
            else
            begin
                root = root_floor({8'b0, diff_sq_acc, 8'b0});
                rec.distance = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
            end
            rec.count = distances_done;
            owed_distances.push_back(rec);
            dot_acc     = '0;
            norm_a_acc  = '0;
            norm_b_acc  = '0;
            diff_sq_acc = '0;
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Observation. One block watches both channels and the register port, so the shadow
    // state and the queue of owed distances change in a fixed order within each edge.
    // ------------------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        dist_record_t due;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (owed_distances.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing owed: expected none, got %h / %0d",
                             $time, res_ch.distance, res_ch.compare_count);
                end
                else
                begin
                    due = owed_distances.pop_front();
                    if (res_ch.distance !== due.distance)
                    begin
                        mismatches++;
                        $display("%0t: distance: expected %h, got %h",
                                 $time, due.distance, res_ch.distance);
                    end
                    if (res_ch.compare_count !== due.count)
                    begin
                        mismatches++;
                        $display("%0t: compare_count: expected %0d, got %0d",
                                 $time, due.count, res_ch.compare_count);
                    end
                end
            end
            if (cfg_we)
                mode_shadow = cfg_wdata;
            if (pair_ch.valid && pair_ch.ready)
                fold_pair(pair_ch.elem_a, pair_ch.elem_b, pair_ch.last);
        end
    end

    // A hung block must not hang the run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d distances owed",
                     $time, owed_distances.size());
            $display("** vector_distance_l2_cosine: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------------------

    // Idle cycles before a beat or before taking a result. During a steady stretch there
    // are none; otherwise a third of the draws give none.
    function automatic int unsigned draw_gap(input bit steady);
        if (steady || $urandom_range(2) == 0)
            return 0;
        return $urandom_range(12);
    endfunction

    // The result side stalls a fresh random number of cycles before every beat it takes.
    initial
    begin : take_results
        int unsigned stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(snk_steady);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Offers one pair beat after a random gap and returns at the edge that takes it.
    // Valid is left high so that a following beat with no gap goes out back to back.
    task automatic send_pair(input elem_t a, input elem_t b, input logic lst);
        int unsigned gap;
        gap = draw_gap(src_steady);
        if (gap != 0)
        begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_ch.valid  <= 1'b1;
        pair_ch.elem_a <= a;
        pair_ch.elem_b <= b;
        pair_ch.last   <= lst;
        do
            @(posedge clk);
        while (!pair_ch.ready);
    endtask

    // Stops the pair stream and waits until every owed distance has come back. Pairs that
    // close no vector give no result, so a fixed hold-off covers their processing too.
    task automatic settle();
        pair_ch.valid <= 1'b0;
        while (owed_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The mode register is written only while the block is idle.
    task automatic write_mode(input logic mode);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic elem_t clamp_elem(input int v);
        if (v > 32767)
            return E_MAX;
        if (v < -32768)
            return E_MIN;
        return elem_t'(v);
    endfunction

    function automatic elem_t extreme_elem();
        case ($urandom_range(5))
            0: return E_MIN;
            1: return E_MIN + 16'sd1;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return E_MAX;
        endcase
    endfunction

    task automatic make_pair(input fill_t fill, output elem_t a, output elem_t b);
        a = elem_t'($urandom);
        b = elem_t'($urandom);
        case (fill)
            FILL_SMALL:
            begin
                a = elem_t'(int'($urandom_range(1024)) - 512);
                b = elem_t'(int'($urandom_range(1024)) - 512);
            end
            FILL_EXTREME:
            begin
                a = extreme_elem();
                b = extreme_elem();
            end
            FILL_SAME:   b = a;
            FILL_NEG:    b = clamp_elem(-int'(a));
            FILL_NEAR:   b = clamp_elem(int'(a) + int'($urandom_range(16)) - 8);
            FILL_A_ZERO: a = '0;
            FILL_B_ZERO: b = '0;
            default: ;
        endcase
    endtask

    // Most vectors are short; some are medium and a few long.
    function automatic int unsigned pick_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(8, 1);
        if (roll < 95)
            return $urandom_range(32, 9);
        return $urandom_range(128, 33);
    endfunction

    // ------------------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------------------

    // Euclidean mode on one-pair vectors at the element extremes, then a two-pair vector
    // whose distance is the square root of two.
    task automatic test_euclid_directed();
        write_mode(MODE_EUCLID);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(E_MAX, E_MIN, 1'b1);
        send_pair(E_MIN, E_MAX, 1'b1);
        send_pair(E_MIN, E_MIN, 1'b1);
        send_pair(Q4_ONE, 16'sd0, 1'b0);
        send_pair(16'sd0, Q4_ONE, 1'b1);
    endtask

    // Cosine mode: zero norms on either side and both, parallel vectors where the cosine
    // must be clamped to one, opposite vectors, orthogonal ones, and mixed extremes.
    task automatic test_cosine_directed();
        write_mode(MODE_COSINE);
        send_pair(16'sd0, 16'sd100, 1'b1);
        send_pair(16'sd100, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(E_MIN, E_MIN, 1'b1);
        send_pair(E_MIN, E_MAX, 1'b1);
        send_pair(E_MAX, E_MAX, 1'b0);
        send_pair(-16'sd1, 16'sd1, 1'b1);
        send_pair(Q4_ONE, 16'sd0, 1'b0);
        send_pair(16'sd0, Q4_ONE, 1'b1);
        send_pair(16'sd3, 16'sd6, 1'b0);
        send_pair(16'sd4, 16'sd8, 1'b1);
    endtask

    // A vector left open keeps its sums across a mode write; it closes under the new mode.
    task automatic test_open_vector();
        send_pair(16'sd1234, -16'sd4321, 1'b0);
        send_pair(E_MIN, 16'sd7, 1'b0);
        write_mode(MODE_EUCLID);
        send_pair(16'sd77, E_MAX, 1'b1);
    endtask

    // Random vectors in one mode. Each vector has its own fill style and its own chance of
    // a steady stretch on either side. One vector in twenty omits its closing mark and so
    // runs on into the next one.
    task automatic test_random_vectors(input logic mode, input int unsigned pairs_wanted);
        int unsigned sent;
        int unsigned len;
        fill_t       fill;
        elem_t       a;
        elem_t       b;
        bit          closes;
        write_mode(mode);
        sent   = 0;
        closes = 1'b1;
        while (sent < pairs_wanted)
        begin
            len        = pick_len();
            fill       = fill_t'($urandom_range(int'(FILL_B_ZERO)));
            closes     = ($urandom_range(19) != 0);
            src_steady = ($urandom_range(4) == 0);
            snk_steady = ($urandom_range(4) == 0);
            for (int k = 0; k < len; k++)
            begin
                make_pair(fill, a, b);
                send_pair(a, b, closes && (k == len - 1));
                sent++;
            end
        end
        // The phase must not end on an open vector.
        if (!closes)
        begin
            make_pair(FILL_FULL, a, b);
            send_pair(a, b, 1'b1);
        end
        src_steady = 1'b0;
        snk_steady = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        pair_ch.valid  = 1'b0;
        pair_ch.elem_a = '0;
        pair_ch.elem_b = '0;
        pair_ch.last   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_euclid_directed();
        test_cosine_directed();
        test_open_vector();
        test_random_vectors(MODE_COSINE, RANDOM_PAIRS);
        test_random_vectors(MODE_EUCLID, RANDOM_PAIRS);
        test_random_vectors(MODE_COSINE, RANDOM_PAIRS);
        test_random_vectors(MODE_EUCLID, RANDOM_PAIRS);
        test_random_vectors(MODE_COSINE, RANDOM_PAIRS);

        // Let the last distances arrive, then watch a while longer for stray result beats.
        settle();
        if (mismatches == 0 && owed_distances.size() == 0)
            $display("** vector_distance_l2_cosine: PASSED **");
        else
            $display("** vector_distance_l2_cosine: FAILED **");
        $finish;
    end

endmodule
